[design/pfu_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the pareto frontier update block
package pfu_pkg;

    localparam int FRONT_DEPTH_DEF = 16;

    localparam int LAT_W   = 32;
    localparam int MEM_W   = 48;
    localparam int TAG_W   = 64;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 5;
    localparam int OC_W    = 3;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // outcome codes
    localparam logic [OC_W-1:0] OC_ADDED     = 3'd0;
    localparam logic [OC_W-1:0] OC_DOMINATED = 3'd1;
    localparam logic [OC_W-1:0] OC_IGNORED   = 3'd2;
    localparam logic [OC_W-1:0] OC_FULL      = 3'd3;
    localparam logic [OC_W-1:0] OC_READ      = 3'd4;

    typedef struct packed {
        logic             cmd;
        logic             gate_passed;
        logic [LAT_W-1:0] latency;
        logic [MEM_W-1:0] mem_use;
        logic [TAG_W-1:0] plan_tag;
        logic [IDX_W-1:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [OC_W-1:0]  outcome;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] frontier_count;
        logic [LAT_W-1:0] low_latency;
        logic [MEM_W-1:0] low_memory;
        logic [LAT_W-1:0] entry_latency;
        logic [MEM_W-1:0] entry_memory;
        logic [TAG_W-1:0] entry_tag;
        logic             entry_valid;
    } t_rsp;

    typedef struct packed {
        logic [LAT_W-1:0] latency;
        logic [MEM_W-1:0] memory;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_CHK,
        S_CMP,
        S_PUSH
    } t_state;

endpackage

[design/pareto_frontier_update_top.sv]
`timescale 1ns / 1ps
// two-objective pareto frontier table with insert and read requests
//
// Keeps up to FRONT_DEPTH points (latency, memory, tag) in insertion order in
// one single-port-read, single-port-write synchronous memory, both objectives
// minimized. Each request gives exactly one response. A read request passes
// through S_RD_WAIT and S_PUSH to the response register; an ignored insert or
// the first point into an empty table goes straight to S_PUSH. Any other
// insert scans the table twice through the memory read port, one entry per
// cycle: a first pass looks for an entry that dominates the candidate, a
// second pass (skipped if one is found) drops the entries the candidate
// dominates and compacts the survivors in place, then appends the candidate
// if a slot is free, so the memory read port sets the rate. One request is in
// work at a time; a finished response waits in the output register while the
// next request is taken. Table entries hold no reset value, only those below
// the count are ever read.
module pareto_frontier_update_top #(
    parameter int FRONT_DEPTH = pfu_pkg::FRONT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  pfu_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output pfu_pkg::t_rsp o_rsp
);
    import pfu_pkg::*;

    localparam int AW   = $clog2(FRONT_DEPTH);
    localparam int CW   = $clog2(FRONT_DEPTH + 1);
    localparam int CMPW = CW + IDX_W;

    // table memory
    t_entry r_mem [FRONT_DEPTH];
    t_entry r_rd_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    // sequencer and architectural state
    t_state r_state, n_state;
    logic [CW-1:0]    r_count,   n_count;
    logic [LAT_W-1:0] r_min_lat, n_min_lat;
    logic [MEM_W-1:0] r_min_mem, n_min_mem;

    // per-request working registers
    t_req             r_req,       n_req;
    logic [OC_W-1:0]  r_outcome,   n_outcome;
    logic [CW-1:0]    r_removed,   n_removed;
    logic [CW-1:0]    r_rd_idx,    n_rd_idx;
    logic [CW-1:0]    r_wr_idx,    n_wr_idx;
    logic             r_rd_pend,   n_rd_pend;
    logic             r_beaten,    n_beaten;
    logic             r_hit,       n_hit;
    t_entry           r_ent,       n_ent;
    logic             r_ent_valid, n_ent_valid;

    // response register
    logic r_out_valid;
    t_rsp r_out;
    t_rsp rsp_next;

    logic   scan_done;
    logic   push_ok;
    logic   rd_hit;
    t_entry cand;

    // a dominates b: no worse on both objectives and strictly better on one
    function automatic logic dominates(
        input logic [LAT_W-1:0] al, input logic [MEM_W-1:0] am,
        input logic [LAT_W-1:0] bl, input logic [MEM_W-1:0] bm
    );
        return (al <= bl) && (am <= bm) && ((al < bl) || (am < bm));
    endfunction

    // both passes end once every issued read has come back
    assign scan_done = (r_rd_idx == r_count) && !r_rd_pend;
    assign push_ok   = !r_out_valid || i_rsp_ready;
    assign rd_hit    = CMPW'(i_req.entry_index) < CMPW'(r_count);
    assign cand      = '{latency: r_req.latency, memory: r_req.mem_use,
                         tag: r_req.plan_tag};

    // memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.cmd == CMD_READ) begin
                        n_state = S_RD_WAIT;
                    end else if (!i_req.gate_passed || (r_count == '0)) begin
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_RD_WAIT: n_state = S_PUSH;
            S_CHK: begin
                if (scan_done) begin
                    n_state = r_beaten ? S_PUSH : S_CMP;
                end
            end
            S_CMP: begin
                if (scan_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (push_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control per state
    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = cand;
        n_count     = r_count;
        n_min_lat   = r_min_lat;
        n_min_mem   = r_min_mem;
        n_req       = r_req;
        n_outcome   = r_outcome;
        n_removed   = r_removed;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_rd_pend   = 1'b0;
        n_beaten    = r_beaten;
        n_hit       = r_hit;
        n_ent       = r_ent;
        n_ent_valid = r_ent_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req       = i_req;
                    n_removed   = '0;
                    n_rd_idx    = '0;
                    n_wr_idx    = '0;
                    n_beaten    = 1'b0;
                    n_hit       = 1'b0;
                    n_ent       = '0;
                    n_ent_valid = 1'b0;
                    n_outcome   = OC_ADDED;
                    if (i_req.cmd == CMD_READ) begin
                        // out-of-range index never touches the memory
                        n_outcome = OC_READ;
                        n_hit     = rd_hit;
                        rd_en     = rd_hit;
                        rd_addr   = AW'(i_req.entry_index);
                    end else if (!i_req.gate_passed) begin
                        n_outcome = OC_IGNORED;
                    end else if (r_count == '0) begin
                        // first point: stored as is, loads both minima
                        wr_en     = 1'b1;
                        wr_addr   = '0;
                        wr_data   = '{latency: i_req.latency,
                                      memory: i_req.mem_use,
                                      tag: i_req.plan_tag};
                        n_count   = CW'(1);
                        n_min_lat = i_req.latency;
                        n_min_mem = i_req.mem_use;
                    end else begin
                        if (i_req.latency < r_min_lat) begin
                            n_min_lat = i_req.latency;
                        end
                        if (i_req.mem_use < r_min_mem) begin
                            n_min_mem = i_req.mem_use;
                        end
                    end
                end
            end
            S_RD_WAIT: begin
                n_ent       = r_hit ? r_rd_data : '0;
                n_ent_valid = r_hit;
            end
            S_CHK: begin
                // pass one: is the candidate beaten by any stored entry
                if (r_rd_idx < r_count) begin
                    rd_en     = 1'b1;
                    rd_addr   = AW'(r_rd_idx);
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend && dominates(r_rd_data.latency, r_rd_data.memory,
                                           r_req.latency, r_req.mem_use)) begin
                    n_beaten = 1'b1;
                end
                if (scan_done) begin
                    n_rd_idx = '0;
                    if (r_beaten) begin
                        n_outcome = OC_DOMINATED;
                    end
                end
            end
            S_CMP: begin
                // pass two: compact survivors; write slot never passes read slot
                if (r_rd_idx < r_count) begin
                    rd_en     = 1'b1;
                    rd_addr   = AW'(r_rd_idx);
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    if (dominates(r_req.latency, r_req.mem_use,
                                  r_rd_data.latency, r_rd_data.memory)) begin
                        n_removed = r_removed + CW'(1);
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(r_wr_idx);
                        wr_data  = r_rd_data;
                        n_wr_idx = r_wr_idx + CW'(1);
                    end
                end
                if (scan_done) begin
                    if (r_wr_idx < CW'(FRONT_DEPTH)) begin
                        wr_en     = 1'b1;
                        wr_addr   = AW'(r_wr_idx);
                        wr_data   = cand;
                        n_count   = r_wr_idx + CW'(1);
                        n_outcome = OC_ADDED;
                    end else begin
                        n_count   = r_wr_idx;
                        n_outcome = OC_FULL;
                    end
                end
            end
            S_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    // response assembled from the committed state
    always_comb begin
        rsp_next.outcome        = r_outcome;
        rsp_next.removed_count  = CNT_W'(r_removed);
        rsp_next.frontier_count = CNT_W'(r_count);
        rsp_next.low_latency    = r_min_lat;
        rsp_next.low_memory     = r_min_mem;
        rsp_next.entry_latency  = r_ent.latency;
        rsp_next.entry_memory   = r_ent.memory;
        rsp_next.entry_tag      = r_ent.tag;
        rsp_next.entry_valid    = r_ent_valid;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_min_lat   <= '0;
            r_min_mem   <= '0;
            r_rd_pend   <= 1'b0;
            r_beaten    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_min_lat <= n_min_lat;
            r_min_mem <= n_min_mem;
            r_rd_pend <= n_rd_pend;
            r_beaten  <= n_beaten;
            if ((r_state == S_PUSH) && push_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_outcome   <= n_outcome;
        r_removed   <= n_removed;
        r_rd_idx    <= n_rd_idx;
        r_wr_idx    <= n_wr_idx;
        r_hit       <= n_hit;
        r_ent       <= n_ent;
        r_ent_valid <= n_ent_valid;
        if ((r_state == S_PUSH) && push_ok) begin
            r_out <= rsp_next;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule
